### src/rotating_key_xor_stream_cipher_macros.svh
// Assertion helpers for the cipher RTL; rkx_keystream uses them.
// Both macros expect signals named clk and rst_n in the using module.
`ifndef ROTATING_KEY_XOR_STREAM_CIPHER_MACROS_SVH
`define ROTATING_KEY_XOR_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RKX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkx assertion failed");

// Next-cycle implication, checked outside reset.
`define RKX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkx assertion failed");

`endif

### src/rkx_pkg.sv
`default_nettype none

package rkx_pkg;

    localparam int KEY_WORDS  = 4;
    localparam int KEY_BYTES  = 32;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 8;

    typedef logic [63:0]                key_word_t;
    typedef key_word_t [KEY_WORDS-1:0]  key_array_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [7:0]                 byte_t;

    localparam pos_t POS_MIX = pos_t'(KEY_BYTES);

    localparam key_word_t MIX_CONST [KEY_WORDS] = '{
        64'h06afd84954b0befb,
        64'h7269a6f2ec9ae170,
        64'hd7e4d06a6f952ae9,
        64'hf7daa8bf37e0e5a0
    };

    localparam int MIX_ROT [KEY_WORDS] = '{7, 13, 17, 23};

    // One configuration write beat as seen by the key logic.
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        key_word_t            data;
    } cfg_write_t;

    function automatic key_word_t rotl64(key_word_t x, int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    // Byte 0 of each word is its most significant byte.
    function automatic byte_t key_byte(key_array_t k, logic [4:0] pos);
        key_word_t word;
        word = k[pos[4:3]];
        return word[{3'd7 - pos[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

### src/rotating_key_xor_stream_cipher.sv
// Byte-wise XOR stream cipher with a 256-bit rotating working key.
// Input channel: in_valid, data_byte, last_in; the block drives in_stall.
// Output channel: out_valid, cipher_byte, last_out; the receiver drives out_stall.
// A beat moves on a channel at a rising edge with valid high and stall low.
// Key words are written on the cfg channel (cfg_index 0 to 3, cfg_data);
// cfg_ready is always high and indexes above 3 are ignored. A key write
// reloads the working key from all four key registers and forces a mix
// before the next byte.
// An accepted byte is registered and appears on the output at the next edge.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the single output register that refills in the same cycle its beat is taken.
// When the receiver stalls with a result waiting, in_stall rises in the same
// cycle and the waiting result holds until it is taken.
// Reset clears the key registers and the working key to zero and sets the
// byte position to 32, so the first byte triggers a mix.
`default_nettype none

module rotating_key_xor_stream_cipher
    import rkx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                cipher_byte,
    output logic                      last_out,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    cfg_write_t cfg_write;
    byte_t      kbyte;
    logic       advance;

    // Key writes are always taken; the user must send them only while the block is idle (not enforced here).
    assign cfg_ready       = 1'b1;
    assign cfg_write.valid = cfg_valid && cfg_ready;
    assign cfg_write.index = cfg_index;
    assign cfg_write.data  = cfg_data;

    // The key position steps on each accepted input beat unless a key write arrives in the same cycle.
    assign advance = in_valid && !in_stall;

    rkx_keystream u_keystream
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .advance   (advance),
        .last      (last_in),
        .kbyte     (kbyte)
    );

    rkx_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_in     (last_in),
        .kbyte       (kbyte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cipher_byte (cipher_byte),
        .last_out    (last_out)
    );

endmodule

`default_nettype wire

### src/rkx_keystream.sv
`default_nettype none
`include "rotating_key_xor_stream_cipher_macros.svh"

module rkx_keystream
    import rkx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_write_t cfg_write,
    input  wire logic       advance,
    input  wire logic       last,
    output byte_t           kbyte
);

    key_array_t key_reg, key_next;
    key_array_t wk_reg, wk_next;
    pos_t       pos_reg, pos_next;

    key_array_t mixed;
    key_array_t eff_key;
    logic [4:0] eff_pos;
    logic       mixing;

    always_comb
    begin
        for (int w = 0; w < KEY_WORDS; w++)
        begin
            mixed[w] = rotl64(wk_reg[w] ^ MIX_CONST[w], MIX_ROT[w]);
        end
    end

    // Any position at or above the key length means the key is mixed first.
    assign mixing  = pos_reg[POS_W-1];
    assign eff_key = mixing ? mixed : wk_reg;
    assign eff_pos = mixing ? 5'd0 : pos_reg[4:0];
    assign kbyte   = key_byte(eff_key, eff_pos);

    always_comb
    begin
        key_next = key_reg;
        wk_next  = wk_reg;
        pos_next = pos_reg;
        if (cfg_write.valid)
        begin
            if (cfg_write.index < CFG_IDX_W'(KEY_WORDS))
            begin
                key_next[cfg_write.index[1:0]] = cfg_write.data;
                wk_next  = key_next;
                pos_next = POS_MIX;
            end
        end
        else if (advance)
        begin
            wk_next  = eff_key;
            pos_next = last ? POS_MIX : pos_t'({1'b0, eff_pos} + 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            wk_reg  <= '0;
            pos_reg <= POS_MIX;
        end
        else
        begin
            key_reg <= key_next;
            wk_reg  <= wk_next;
            pos_reg <= pos_next;
        end
    end

    `RKX_ASSERT_NEXT(a_cfg_sets_mix,
        cfg_write.valid && cfg_write.index < CFG_IDX_W'(KEY_WORDS), pos_reg == POS_MIX)
    `RKX_ASSERT_NEXT(a_last_sets_mix,
        !cfg_write.valid && advance && last, pos_reg == POS_MIX)
    `RKX_ASSERT_NEXT(a_mix_restarts,
        !cfg_write.valid && advance && !last && mixing, pos_reg == pos_t'(1))
    `RKX_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= POS_MIX)

endmodule

`default_nettype wire

### src/rkx_out_reg.sv
`default_nettype none

module rkx_out_reg
    import rkx_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire byte_t data_byte,
    input  wire logic  last_in,
    input  wire byte_t kbyte,
    output logic       out_valid,
    input  wire logic  out_stall,
    output byte_t      cipher_byte,
    output logic       last_out
);

    logic  out_valid_reg, out_valid_next;
    byte_t cipher_reg;
    logic  last_reg;
    logic  load;

    // The register refills in the same cycle its beat is taken.
    assign in_stall = out_valid_reg && out_stall;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cipher_reg <= data_byte ^ kbyte;
            last_reg   <= last_in;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_reg;
    assign last_out    = last_reg;

endmodule

`default_nettype wire
